// ===== rtl/ile_pkg.sv =====
package ile_pkg;

    localparam int ILE_CAPACITY = 64;
    localparam int ILE_DATA_W   = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_WRITE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/ile_ctrl.sv =====
module ile_ctrl
    import ile_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register must be free or drained this cycle
                if (!r_out_valid || i_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/ile_datapath.sv =====
module ile_datapath
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [1:0]                   i_action,
    input  logic [CNT_W-1:0]             i_position,
    input  logic signed [ILE_DATA_W-1:0] i_item_value,
    output logic signed [ILE_DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]             o_list_count,
    output logic [1:0]                   o_status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_action                 r_act;
    logic [CNT_W-1:0]        r_pos;
    logic [ILE_DATA_W-1:0]   r_val;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ILE_DATA_W-1:0]   r_rd_value, n_rd_value;
    t_status                 r_status, n_status;
    logic [ILE_DATA_W-1:0]   r_cells [CAPACITY];
    logic                    upd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_pos <= i_position;
            r_val <= i_item_value;
        end
    end

    always_comb begin
        n_status   = ST_OK;
        n_rd_value = '0;
        n_count    = r_count;
        if (r_act == ACT_INSERT) begin
            if (r_pos > r_count) begin
                n_status = ST_RANGE;
            end else if (r_count >= CNT_W'(CAPACITY)) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (r_pos >= r_count) begin
            n_status = ST_RANGE;
        end else if (r_act == ACT_REMOVE) begin
            n_count = r_count - CNT_W'(1);
        end else if (r_act == ACT_READ) begin
            n_rd_value = r_cells[r_pos[IDX_W-1:0]];
        end
    end

    assign upd = i_cmd.exec && (n_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_value <= n_rd_value;
            r_status   <= n_status;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        logic [ILE_DATA_W-1:0] w_lower;
        logic [ILE_DATA_W-1:0] w_upper;

        if (g > 0) begin : g_lo
            assign w_lower = r_cells[g-1];
        end else begin : g_lo0
            assign w_lower = r_cells[g];
        end
        if (g < CAPACITY - 1) begin : g_hi
            assign w_upper = r_cells[g+1];
        end else begin : g_hi0
            assign w_upper = r_cells[g];
        end

        always_ff @(posedge i_clk) begin
            if (upd) begin
                case (r_act)
                    ACT_INSERT: begin
                        if (IDX == r_pos) begin
                            r_cells[g] <= r_val;
                        end else if (IDX > r_pos && IDX <= r_count) begin
                            r_cells[g] <= w_lower;
                        end
                    end
                    ACT_REMOVE: begin
                        if (IDX >= r_pos && IDX < r_count - CNT_W'(1)) begin
                            r_cells[g] <= w_upper;
                        end
                    end
                    ACT_WRITE: begin
                        if (IDX == r_pos) begin
                            r_cells[g] <= r_val;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_read_value = r_rd_value;
    assign o_list_count = r_count;
    assign o_status     = r_status;

endmodule

// ===== rtl/indexed_list_engine_core.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// registers. Each request inserts at, removes at, reads or overwrites one
// position and returns one result: read value (zero unless a good read),
// list length after the request and status (ok, bad position, full). A
// failed request leaves the list as it was. Requests are handled one at a
// time: a request is taken in the idle state and executed in the exec
// state, where all entries shift in parallel. A new request is taken while
// the previous result still waits; execution waits for the result register
// to drain.
module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_action,
    input  logic [CNT_W-1:0]             i_position,
    input  logic signed [ILE_DATA_W-1:0] i_item_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ILE_DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]             o_list_count,
    output logic [1:0]                   o_status
);

    t_cmd w_cmd;

    ile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    ile_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_read_value (o_read_value),
        .o_list_count (o_list_count),
        .o_status     (o_status)
    );

endmodule

// ===== rtl/ile_checker.sv =====
module ile_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [ILE_DATA_W-1:0] o_read_value,
    input logic [CNT_W-1:0]             o_list_count,
    input logic [1:0]                   o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_value)
            && $stable(o_list_count) && $stable(o_status))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while another executes");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_RANGE || o_status == ST_FULL)
        else $error("undefined status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_read_value == '0)
        else $error("failed request returned data");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_list_count <= CNT_W'(CAPACITY))
        else $error("length beyond capacity");

endmodule

bind indexed_list_engine_core ile_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_ile_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_read_value (o_read_value),
    .o_list_count (o_list_count),
    .o_status     (o_status)
);

// ===== dv/indexed_list_engine_core_tb.sv =====
module indexed_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int CNT_W     = $clog2(ILE_CAPACITY + 1);
    localparam int HOLD_LEN  = 60;
    localparam int IDLE_PCT  = 26;

    typedef struct {
        logic signed [ILE_DATA_W-1:0] read_value;
        logic [CNT_W-1:0]             list_count;
        t_status                      status;
    } t_list_result;

    logic                         i_clk;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_action     = ACT_READ;
    logic [CNT_W-1:0]             i_position   = '0;
    logic signed [ILE_DATA_W-1:0] i_item_value = '0;
    logic                         o_valid;
    logic                         i_ready      = 1'b0;
    logic signed [ILE_DATA_W-1:0] o_read_value;
    logic [CNT_W-1:0]             o_list_count;
    logic [1:0]                   o_status;

    indexed_list_engine_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_list_count (o_list_count),
        .o_status     (o_status)
    );

    logic signed [ILE_DATA_W-1:0] shadow_list [ILE_CAPACITY];
    int                           shadow_count = 0;
    t_list_result                 pending_results [$];

    int          error_count  = 0;
    int unsigned action_hits [4];
    int unsigned status_hits [3];
    int          peak_count   = 0;

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_list_result predict_request(t_action act, int pos,
                                                     logic signed [ILE_DATA_W-1:0] val);
        t_list_result res;
        res.read_value = '0;
        res.status     = ST_OK;
        if (act == ACT_INSERT) begin
            if (pos > shadow_count) begin
                res.status = ST_RANGE;
            end else if (shadow_count >= ILE_CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (int i = shadow_count; i > pos; i--)
                    shadow_list[i] = shadow_list[i-1];
                shadow_list[pos] = val;
                shadow_count++;
            end
        end else if (pos >= shadow_count) begin
            res.status = ST_RANGE;
        end else if (act == ACT_REMOVE) begin
            for (int i = pos; i + 1 < shadow_count; i++)
                shadow_list[i] = shadow_list[i+1];
            shadow_count--;
        end else if (act == ACT_READ) begin
            res.read_value = shadow_list[pos];
        end else begin
            shadow_list[pos] = val;
        end
        res.list_count = CNT_W'(shadow_count);
        action_hits[act]++;
        status_hits[res.status]++;
        if (shadow_count > peak_count) peak_count = shadow_count;
        return res;
    endfunction

    function automatic logic signed [ILE_DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // Caller sits at a clock edge; returns at the edge where the transfer happened.
    task automatic send_request(t_action act, int pos, logic signed [ILE_DATA_W-1:0] val);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_position   <= CNT_W'(pos);
        i_item_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_request(act, pos, val));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Receiver side; a hold request blocks the result channel, then clears itself.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= stalls_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value, o_read_value);
                    error_count++;
                end
                if (o_list_count !== want.list_count) begin
                    $error("list_count: expected %0d, got %0d", want.list_count, o_list_count);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_request(ACT_READ, 0, '0);
        send_request(ACT_REMOVE, 0, '0);
        send_request(ACT_WRITE, 0, 32'sh1234_5678);
        send_request(ACT_INSERT, 1, 32'sh0bad_0bad);
        send_request(ACT_INSERT, 127, -1);
        send_request(ACT_READ, 127, '0);
        drain_results();
    endtask

    task automatic test_basic_ops();
        send_request(ACT_INSERT, 0, 32'sh7fff_ffff);
        send_request(ACT_INSERT, 0, 32'sh8000_0000);
        send_request(ACT_INSERT, 2, '0);
        send_request(ACT_INSERT, 1, -1);
        send_request(ACT_INSERT, 5, 32'sh55aa_55aa);
        for (int i = 0; i < 4; i++)
            send_request(ACT_READ, i, -1);
        send_request(ACT_WRITE, 3, 32'shdead_beef);
        send_request(ACT_READ, 3, '0);
        send_request(ACT_WRITE, 4, 32'sh0000_0001);
        send_request(ACT_REMOVE, 1, 32'sh7fff_ffff);
        send_request(ACT_REMOVE, 3, '0);
        send_request(ACT_READ, 3, '0);
        send_request(ACT_REMOVE, 2, '0);
        send_request(ACT_REMOVE, 0, '0);
        send_request(ACT_READ, 0, '0);
        send_request(ACT_REMOVE, 0, '0);
        drain_results();
    endtask

    task automatic test_full_list();
        while (shadow_count < ILE_CAPACITY)
            send_request(ACT_INSERT, $urandom_range(shadow_count), pick_value());
        send_request(ACT_INSERT, ILE_CAPACITY, pick_value());
        send_request(ACT_INSERT, 0, pick_value());
        send_request(ACT_INSERT, ILE_CAPACITY + 1, pick_value());
        send_request(ACT_INSERT, 127, pick_value());
        send_request(ACT_READ, ILE_CAPACITY - 1, '0);
        send_request(ACT_WRITE, ILE_CAPACITY - 1, pick_value());
        send_request(ACT_READ, ILE_CAPACITY - 1, '0);
        send_request(ACT_READ, ILE_CAPACITY, '0);
        send_request(ACT_REMOVE, ILE_CAPACITY, '0);
        send_request(ACT_REMOVE, ILE_CAPACITY - 1, '0);
        while (shadow_count > 0) begin
            if ($urandom_range(3) == 0)
                send_request(ACT_READ, $urandom_range(shadow_count - 1), pick_value());
            else
                send_request(ACT_REMOVE, $urandom_range(shadow_count - 1), pick_value());
        end
        send_request(ACT_READ, 0, '0);
        drain_results();
    endtask

    task automatic test_result_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
            if (i < 8)
                send_request(ACT_INSERT, $urandom_range(shadow_count), pick_value());
            else
                send_request(t_action'($urandom_range(3)),
                             $urandom_range(shadow_count), pick_value());
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(int n_items);
        bit      grow;
        int      pick;
        int      pos;
        t_action act;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) grow = $urandom_range(1);
            if (k == n_items / 3) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (k == n_items / 3 + 100) begin
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
            end
            if ($urandom_range(99) < 10) begin
                act = t_action'($urandom_range(3));
                pos = $urandom_range(127);
            end else begin
                pick = $urandom_range(99);
                if (pick < 20)
                    act = ACT_READ;
                else if (pick < 40)
                    act = ACT_WRITE;
                else if (pick < 85)
                    act = grow ? ACT_INSERT : ACT_REMOVE;
                else
                    act = grow ? ACT_REMOVE : ACT_INSERT;
                if (act == ACT_INSERT)
                    pos = $urandom_range(shadow_count);
                else
                    pos = (shadow_count == 0) ? 0 : $urandom_range(shadow_count - 1);
            end
            send_request(act, pos, pick_value());
        end
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_result_backpressure();
        test_random_traffic(350);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Requests: %0d insert, %0d remove, %0d read, %0d overwrite; peak length %0d",
                 action_hits[ACT_INSERT], action_hits[ACT_REMOVE],
                 action_hits[ACT_READ], action_hits[ACT_WRITE], peak_count);
        $display("Outcomes: %0d ok, %0d bad position, %0d list full",
                 status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_FULL]);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
